// ----- rtl/hebbian_weight_update_assert.svh -----
// Assertion macros for the Hebbian weight update block.
// Expects clk and rst in the scope where a macro is used.
`ifndef HEBBIAN_WEIGHT_UPDATE_ASSERT_SVH
`define HEBBIAN_WEIGHT_UPDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HWU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define HWU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hwu_pkg.sv -----
// Shared widths and fixed-point constants for the Hebbian weight update block.
// No dependencies.
package hwu_pkg;

  localparam int unsigned WEIGHT_W = 24;  // signed Q8.16 input weight
  localparam int unsigned MAG_W    = 23;  // unsigned Q7.16 magnitude
  localparam int unsigned ACT_W    = 17;  // unsigned Q1.16 activity / gain
  localparam int unsigned OUT_W    = 27;  // signed Q11.16 result

  localparam logic [MAG_W-1:0] W_FLOOR = 23'd327680;  // 5.0
  localparam logic [MAG_W-1:0] W_TWO   = 23'd131072;  // 2.0
  localparam logic [ACT_W-1:0] Q_ONE   = 17'd65536;   // 1.0

  localparam logic signed [OUT_W-1:0] OUT_MAX = 27'sh3FFFFFF;
  localparam logic signed [OUT_W-1:0] OUT_MIN = -27'sh4000000;

endpackage

// ----- rtl/hebbian_weight_update.sv -----
// Hebbian weight update: one synapse per request through a six-stage pipeline.
// Depends on hwu_pkg and hebbian_weight_update_assert.svh.
//
// Takes a signed Q8.16 weight, Q1.16 pre/post activities and two Q1.16 gains,
// and returns the updated weight as a saturated signed Q11.16 value. One request
// is accepted every cycle while the output side is not stalled. The pipeline
// holds the multipliers (activity triple products over stages 1 and 2, then the
// products with the weight terms in stage 4), each followed by a register, plus
// the gain rounding, summing and final rounding and saturating stages.
// The maximum magnitude register (cfg_write/cfg_data) is floored at 5.0 when
// written and must only be changed while the pipeline is empty.
module hebbian_weight_update (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [hwu_pkg::MAG_W-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [hwu_pkg::WEIGHT_W-1:0] weight_in,
  input  logic [hwu_pkg::ACT_W-1:0]          pre_activity,
  input  logic [hwu_pkg::ACT_W-1:0]          post_activity,
  input  logic [hwu_pkg::ACT_W-1:0]          hebb_gain,
  input  logic [hwu_pkg::ACT_W-1:0]          pre_gain,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [hwu_pkg::OUT_W-1:0]   weight_out
);

  `include "hebbian_weight_update_assert.svh"

  // Floored maximum magnitude
  logic [22:0] max_mag;

  // Stage valids and enables
  logic [6:1] v;
  logic [6:1] en;

  // Stage 1
  logic [22:0] s1_m;
  logic        s1_neg, s1_post_low;
  logic [16:0] s1_post, s1_dpost;
  logic [33:0] s1_hp, s1_pp;
  // Stage 2
  logic [50:0] s2_hq, s2_pq;
  logic [22:0] s2_diff, s2_top, s2_m;
  logic        s2_neg, s2_post_low;
  // Stage 3
  logic [19:0] s3_ga, s3_gb;
  logic [22:0] s3_ma, s3_m;
  logic [23:0] s3_mb;
  logic        s3_neg, s3_na, s3_nb;
  // Stage 4
  logic [42:0] s4_pa;
  logic [43:0] s4_pb;
  logic [22:0] s4_m;
  logic        s4_neg, s4_na, s4_nb;
  // Stage 5
  logic signed [45:0] s5_x;

  // Combinational next values
  logic [23:0]        wabs;
  logic [22:0]        m_next;
  logic [16:0]        dpost_next;
  logic [23:0]        top_sum;
  logic [22:0]        top_next;
  logic [51:0]        hq_rnd, pq_rnd;
  logic [19:0]        g_hebb, g_pre;
  logic signed [45:0] t_m, t_a, t_b, x_next;
  logic signed [46:0] y;
  logic signed [30:0] r;
  logic signed [26:0] weight_out_next;

  // Ready chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[6] = !v[6] || out_ready;
    en[5] = !v[5] || en[6];
    en[4] = !v[4] || en[5];
    en[3] = !v[3] || en[4];
    en[2] = !v[2] || en[3];
    en[1] = !v[1] || en[2];
  end

  assign in_ready  = en[1];
  assign out_valid = v[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      max_mag <= hwu_pkg::W_FLOOR;
    end else if (cfg_write) begin
      max_mag <= (cfg_data < hwu_pkg::W_FLOOR) ? hwu_pkg::W_FLOOR : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= in_valid;
      if (en[2]) v[2] <= v[1];
      if (en[3]) v[3] <= v[2];
      if (en[4]) v[4] <= v[3];
      if (en[5]) v[5] <= v[4];
      if (en[6]) v[6] <= v[5];
    end
  end

  // Stage 1: clamp and magnitude, first gain products
  always_comb begin
    wabs       = weight_in[23] ? 24'(-weight_in) : 24'(weight_in);
    m_next     = (wabs > {1'b0, max_mag}) ? max_mag : wabs[22:0];
    dpost_next = post_activity[16] ? {1'b0, post_activity[15:0]}
                                   : 17'(hwu_pkg::Q_ONE - post_activity);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_m        <= m_next;
      s1_neg      <= weight_in[23];
      s1_post_low <= !post_activity[16];
      s1_post     <= post_activity;
      s1_dpost    <= dpost_next;
      s1_hp       <= 34'(hebb_gain) * 34'(pre_activity);
      s1_pp       <= 34'(pre_gain) * 34'(pre_activity);
    end
  end

  // Stage 2: triple products, headroom and cap
  always_comb begin
    top_sum  = {1'b0, s1_m} + {1'b0, hwu_pkg::W_TWO};
    top_next = (top_sum > {1'b0, max_mag}) ? max_mag : top_sum[22:0];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_hq       <= 51'(s1_hp) * 51'(s1_post);
      s2_pq       <= 51'(s1_pp) * 51'(s1_dpost);
      s2_diff     <= max_mag - s1_m;
      s2_top      <= top_next;
      s2_m        <= s1_m;
      s2_neg      <= s1_neg;
      s2_post_low <= s1_post_low;
    end
  end

  // Stage 3: round gains to Q4.16, steer operands by the weight's sign
  always_comb begin
    hq_rnd = {1'b0, s2_hq} + 52'h0_0000_8000_0000;
    pq_rnd = {1'b0, s2_pq} + 52'h0_0000_8000_0000;
    g_hebb = hq_rnd[51:32];
    g_pre  = pq_rnd[51:32];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_ga  <= s2_neg ? g_pre : g_hebb;
      s3_gb  <= s2_neg ? g_hebb : g_pre;
      s3_ma  <= s2_diff;
      s3_mb  <= s2_neg ? ({1'b0, s2_top} + {1'b0, hwu_pkg::W_TWO}) : {1'b0, s2_top};
      s3_m   <= s2_m;
      s3_neg <= s2_neg;
      // Signs after the final negation of an inhibitory weight
      s3_na  <= s2_neg && s2_post_low;
      s3_nb  <= !s2_neg && s2_post_low;
    end
  end

  // Stage 4: weight-term products
  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_pa  <= 43'(s3_ga) * 43'(s3_ma);
      s4_pb  <= 44'(s3_gb) * 44'(s3_mb);
      s4_m   <= s3_m;
      s4_neg <= s3_neg;
      s4_na  <= s3_na;
      s4_nb  <= s3_nb;
    end
  end

  // Stage 5: signed Q.32 sum
  always_comb begin
    t_m    = $signed({7'd0, s4_m, 16'd0});
    t_a    = $signed({3'd0, s4_pa});
    t_b    = $signed({2'd0, s4_pb});
    x_next = (s4_neg ? -t_m : t_m) + (s4_na ? -t_a : t_a) + (s4_nb ? -t_b : t_b);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_x <= x_next;
    end
  end

  // Stage 6: round half up to Q.16, saturate
  always_comb begin
    y = {s5_x[45], s5_x} + 47'sd32768;
    r = y[46:16];
    if (r > 31'(hwu_pkg::OUT_MAX)) begin
      weight_out_next = hwu_pkg::OUT_MAX;
    end else if (r < 31'(hwu_pkg::OUT_MIN)) begin
      weight_out_next = hwu_pkg::OUT_MIN;
    end else begin
      weight_out_next = r[26:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      weight_out <= weight_out_next;
    end
  end

  `HWU_ASSERT_NOW(a_no_backpressure_when_drained, out_ready, in_ready, "input stalled while output is free")
  `HWU_ASSERT_NEXT(a_stage5_reaches_output, v[5] && en[6], out_valid, "request lost before output")
  `HWU_ASSERT_NOW(a_cap_bound, v[2], {1'b0, s2_top} <= ({1'b0, s2_m} + {1'b0, hwu_pkg::W_TWO}), "cap above magnitude plus two")

endmodule
